FILE: rtl/core/threshold_trigger_window_capture_macros.svh
`ifndef THRESHOLD_TRIGGER_WINDOW_CAPTURE_MACROS_SVH
`define THRESHOLD_TRIGGER_WINDOW_CAPTURE_MACROS_SVH

// same-cycle implication
`define TTWC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ttwc check failed");

// next-cycle implication
`define TTWC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ttwc check failed");

`endif

FILE: rtl/core/ttwc_pkg.sv
package ttwc_pkg;

   localparam int PRE_SAMPLES_DEF   = 50;
   localparam int WINDOW_LENGTH_DEF = 750;

   localparam int SAMPLE_BITS = 12;
   localparam int POS_W       = 10;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;

   localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(100);

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [POS_W-1:0]       position_type;

   typedef struct packed {
      position_type pos;
      logic         trig;
      logic         last;
   } window_tag_type;

endpackage

FILE: rtl/core/ttwc_delay_line.sv
module ttwc_delay_line #(
   parameter int PRE_SAMPLES = ttwc_pkg::PRE_SAMPLES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  ttwc_pkg::sample_type wr_sample,
   output ttwc_pkg::sample_type rd_sample
);
   import ttwc_pkg::*;

   localparam int PTR_W = (PRE_SAMPLES > 1) ? $clog2(PRE_SAMPLES) : 1;

   sample_type       history_mem [PRE_SAMPLES];
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic             wrapped_ff, wrapped_in;
   sample_type       rd_ff;
   logic             rd_valid_ff;

   always_comb begin
      ptr_in     = ptr_ff;
      wrapped_in = wrapped_ff;
      if (wr_en) begin
         if (ptr_ff == PTR_W'(PRE_SAMPLES - 1)) begin
            ptr_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            ptr_in = ptr_ff + PTR_W'(1);
         end
      end
   end

   // read-before-write on the same slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rd_ff                <= history_mem[ptr_ff];
         history_mem[ptr_ff] <= wr_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         wrapped_ff  <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         ptr_ff     <= ptr_in;
         wrapped_ff <= wrapped_in;
         if (wr_en) begin
            rd_valid_ff <= wrapped_ff;
         end
      end
   end

   // slots not yet written since reset read as zero
   assign rd_sample = rd_valid_ff ? rd_ff : '0;

endmodule

FILE: rtl/core/ttwc_window_ctrl.sv
`include "threshold_trigger_window_capture_macros.svh"

module ttwc_window_ctrl #(
   parameter int PRE_SAMPLES   = ttwc_pkg::PRE_SAMPLES_DEF,
   parameter int WINDOW_LENGTH = ttwc_pkg::WINDOW_LENGTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  ttwc_pkg::sample_type    csr_data,
   input  logic                    accept,
   input  ttwc_pkg::sample_type    sample,
   output logic                    emit,
   output ttwc_pkg::window_tag_type tag
);
   import ttwc_pkg::*;

   localparam int CNT_W = $clog2(WINDOW_LENGTH);

   sample_type       threshold_ff;
   logic             capturing_ff, capturing_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pos;
   logic             last;

   always_comb begin
      emit = capturing_ff || (sample > threshold_ff);
      pos  = capturing_ff ? count_ff : '0;
      last = (pos == CNT_W'(WINDOW_LENGTH - 1));

      tag.pos  = POS_W'(pos);
      tag.trig = (32'(pos) == 32'(PRE_SAMPLES));
      tag.last = last;

      capturing_in = capturing_ff;
      count_in     = count_ff;
      if (accept && emit) begin
         capturing_in = !last;
         count_in     = last ? '0 : pos + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         capturing_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (csr_valid) begin
            threshold_ff <= csr_data;
         end
         capturing_ff <= capturing_in;
         count_ff     <= count_in;
      end
   end

   `TTWC_ASSERT_NOW(a_armed_count_zero, !capturing_ff, count_ff == '0)
   `TTWC_ASSERT_NEXT(a_window_continues, accept && emit && !last, capturing_ff)
   `TTWC_ASSERT_NEXT(a_rearm_after_last, accept && emit && last, !capturing_ff)

endmodule

FILE: rtl/core/threshold_trigger_window_capture.sv
// Level trigger with pre-trigger capture. One sample word is accepted per clock,
// sustained, unless output back-pressure stalls the input; results pass through
// the s1 stage and the output register. The delay-line memory does one read and
// one write of the same slot for every accepted word. While armed, a sample
// above the threshold starts a window of WINDOW_LENGTH result words: the
// PRE_SAMPLES samples before the trigger, the trigger sample (is_trigger,
// position PRE_SAMPLES), then the following samples; tlast marks the final word
// and the block re-arms on the next input. Slots not yet written since reset
// read as zero, with no clearing pass. Write the threshold only while the block is idle.

`include "threshold_trigger_window_capture_macros.svh"

module threshold_trigger_window_capture #(
   parameter int PRE_SAMPLES   = ttwc_pkg::PRE_SAMPLES_DEF,
   parameter int WINDOW_LENGTH = ttwc_pkg::WINDOW_LENGTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ttwc_pkg::REQ_DATA_W-1:0] req_tdata,  // [11:0] adc_sample
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ttwc_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [11:0] window_sample,
                                                       // [21:12] window_position
   output logic                            rsp_tuser,  // is_trigger
   output logic                            rsp_tlast,  // last_of_window
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  ttwc_pkg::sample_type            csr_data    // trigger_threshold
);
   import ttwc_pkg::*;

   localparam position_type LAST_POS = POS_W'(WINDOW_LENGTH - 1);

   logic           accept;
   logic           out_free;
   logic           emit;
   sample_type     sample;
   sample_type     delayed;
   window_tag_type tag;

   logic           s1_valid_ff, s1_valid_in;
   window_tag_type s1_tag_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   window_tag_type rsp_tag_ff;
   sample_type     rsp_sample_ff;

   assign sample     = req_tdata[SAMPLE_BITS-1:0];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   ttwc_delay_line #(
      .PRE_SAMPLES(PRE_SAMPLES)
   ) u_delay_line (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept),
      .wr_sample(sample),
      .rd_sample(delayed)
   );

   ttwc_window_ctrl #(
      .PRE_SAMPLES  (PRE_SAMPLES),
      .WINDOW_LENGTH(WINDOW_LENGTH)
   ) u_window_ctrl (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_data (csr_data),
      .accept   (accept),
      .sample   (sample),
      .emit     (emit),
      .tag      (tag)
   );

   always_comb begin
      if (accept) begin
         s1_valid_in = emit;
      end else begin
         s1_valid_in = s1_valid_ff && !out_free;
      end

      if (s1_valid_ff && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tag_ff <= tag;
      end
      if (s1_valid_ff && out_free) begin
         rsp_tag_ff    <= s1_tag_ff;
         rsp_sample_ff <= delayed;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_tag_ff.pos, rsp_sample_ff});
   assign rsp_tuser  = rsp_tag_ff.trig;
   assign rsp_tlast  = rsp_tag_ff.last;

   `TTWC_ASSERT_NOW(a_last_position, rsp_valid_ff && rsp_tag_ff.last, rsp_tag_ff.pos == LAST_POS)
   `TTWC_ASSERT_NEXT(a_stage_holds, s1_valid_ff && !out_free, s1_valid_ff)
   `TTWC_ASSERT_NEXT(a_emit_enters_stage, accept && emit, s1_valid_ff)

endmodule
